[rtl/core/clswh_pkg.sv]
// Shared codes, register indexes and helpers for the chat line cleaner.
package clswh_pkg;

   // Widths fixed by the beat layout
   localparam int BYTE_W        = 8;
   localparam int KEY_W         = 64;
   localparam int KEY_LEN_W     = 4;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 64;
   localparam int KEY_COUNT     = 3;
   localparam int KEY_CHARS_DEF = 8;

   localparam logic [BYTE_W-1:0] WRAP_WIDTH_RESET = 8'd80;

   // Control and replacement bytes
   localparam logic [BYTE_W-1:0] CHAR_NUL       = 8'h00;
   localparam logic [BYTE_W-1:0] CHAR_BOLD      = 8'h02;
   localparam logic [BYTE_W-1:0] CHAR_COLOR     = 8'h03;
   localparam logic [BYTE_W-1:0] CHAR_RESET     = 8'h0F;
   localparam logic [BYTE_W-1:0] CHAR_REVERSE   = 8'h16;
   localparam logic [BYTE_W-1:0] CHAR_UNDERLINE = 8'h1F;
   localparam logic [BYTE_W-1:0] CHAR_COMMA     = 8'h2C;
   localparam logic [BYTE_W-1:0] CHAR_ZERO      = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_NINE      = 8'h39;
   localparam logic [BYTE_W-1:0] CHAR_QUESTION  = 8'h3F;
   localparam logic [BYTE_W-1:0] CHAR_CR        = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_LF        = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_UPPER_A   = 8'h41;
   localparam logic [BYTE_W-1:0] CHAR_UPPER_Z   = 8'h5A;
   localparam logic [BYTE_W-1:0] CASE_OFFSET    = 8'h20;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WRAP_WIDTH   = 3'd0,
      CSR_KEY_A        = 3'd1,
      CSR_KEY_A_LENGTH = 3'd2,
      CSR_KEY_B        = 3'd3,
      CSR_KEY_B_LENGTH = 3'd4,
      CSR_KEY_C        = 3'd5,
      CSR_KEY_C_LENGTH = 3'd6
   } csr_index_type;

   // Color code stripping phase, one-hot
   typedef enum logic [2:0] {
      PH_TEXT  = 3'b001,
      PH_COLOR = 3'b010,
      PH_COMMA = 3'b100
   } strip_phase_type;

   // Results still owed for one input beat, lowest bit goes out first
   typedef struct packed {
      logic beep;
      logic lf;
      logic cr;
      logic text;
   } pend_type;

   function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] c);
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         return c + CASE_OFFSET;
      end
      return c;
   endfunction

endpackage

[rtl/core/chat_line_code_strip_wrap_highlight_unit.sv]
// Chat line cleaner: code stripping, row wrap with CR LF, keyword highlight beep.
//
// One raw byte of a chat line comes in per req beat, tlast on the line's last byte.
// Bold, underline, reverse and reset codes are dropped; a color code goes with its
// digits, one comma and the digits after it; bytes of 0x80 and up turn into '?';
// a NUL ends the line's text and later bytes up to tlast are ignored. Cleaned bytes
// go out on rsp with CR LF after every wrap_width bytes and after a partial last row.
// If any of the three keywords matched anywhere in the cleaned text, one beep beat
// (tdata zero, tuser high) follows the line's text. rsp tlast marks the last beat
// of a line; a line that gives no beat at all gives no tlast. Each accepted byte is
// decoded in the cycle it is taken; its results (at most four) are queued in a small
// pending set that the output register drains one beat per cycle while rsp_tready
// is high. A byte with zero or one result lets the next byte in straight away, so
// plain text runs at one byte per clock unless rsp stalls; a byte with more holds
// req off until only its last result is left. Config writes are taken at any time
// (csr_ready is tied high) but should only be done while the unit is idle.
module chat_line_code_strip_wrap_highlight_unit #(
   parameter int KEY_CHARS = clswh_pkg::KEY_CHARS_DEF   // 1..8 keyword chars compared
) (
   input  logic                                clock,
   input  logic                                reset,
   // input byte stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [clswh_pkg::BYTE_W-1:0]        req_tdata,   // [7:0] in_byte
   input  logic                                req_tlast,   // end_of_line
   // result stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [clswh_pkg::BYTE_W-1:0]        rsp_tdata,   // [7:0] out_byte
   output logic                                rsp_tuser,   // [0] is_beep
   output logic                                rsp_tlast,   // line_done
   // configuration writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [clswh_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [clswh_pkg::CSR_DATA_W-1:0]    csr_data
);
   import clswh_pkg::*;

   localparam int RECENT_W = BYTE_W * KEY_CHARS;
   localparam logic [KEY_LEN_W-1:0] KEY_CHARS_LEN = KEY_LEN_W'(KEY_CHARS);

   // config registers
   logic [BYTE_W-1:0]    wrap_width_ff;
   logic [KEY_W-1:0]     key_ff     [KEY_COUNT];
   logic [KEY_LEN_W-1:0] key_len_ff [KEY_COUNT];

   // line state
   strip_phase_type      phase_ff, phase_in;
   logic [BYTE_W-1:0]    row_ff, row_in;
   logic [RECENT_W-1:0]  recent_ff, recent_in;
   logic                 seen_ff, seen_in;
   logic                 ended_ff, ended_in;

   // pending results of the last accepted beat
   pend_type             pend_ff, pend_in;
   logic [BYTE_W-1:0]    text_ff, text_in;
   logic                 eol_ff, eol_in;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]    rsp_data_ff, rsp_data_in;
   logic                 rsp_user_ff, rsp_user_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 req_accept;
   logic                 out_free;
   logic                 out_load;
   logic                 pend_busy;

   // byte decode
   logic [BYTE_W-1:0]    in_byte;
   logic                 is_digit;
   logic                 handle;
   logic                 emit;
   logic [BYTE_W-1:0]    clean;
   logic [BYTE_W-1:0]    width_eff;
   logic [BYTE_W-1:0]    row_inc;
   logic                 wrap;
   logic                 match;
   logic [RECENT_W-1:0]  recent_shift;
   logic [KEY_LEN_W-1:0] len_eff;
   logic                 hit;
   logic [BYTE_W-1:0]    key_byte;
   pend_type             pend_new;
   pend_type             pend_drop;

   assign csr_ready  = 1'b1;
   assign pend_busy  = |pend_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign out_load   = out_free && pend_busy;
   // take a new byte once at most the last owed result is left and it leaves now
   assign req_tready = !pend_busy || ($onehot(pend_ff) && out_free);
   assign req_accept = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   // strip, wrap and match for the incoming byte
   always_comb begin
      in_byte  = req_tdata;
      is_digit = (in_byte >= CHAR_ZERO) && (in_byte <= CHAR_NINE);
      phase_in = phase_ff;
      ended_in = ended_ff;
      handle   = 1'b0;
      emit     = 1'b0;
      clean    = in_byte;

      if (!ended_ff) begin
         handle = 1'b1;
         unique case (phase_ff)
            PH_COLOR: begin
               if (is_digit) begin
                  handle = 1'b0;
               end else if (in_byte == CHAR_COMMA) begin
                  phase_in = PH_COMMA;
                  handle   = 1'b0;
               end else begin
                  phase_in = PH_TEXT;
               end
            end
            PH_COMMA: begin
               if (is_digit) begin
                  handle = 1'b0;
               end else begin
                  phase_in = PH_TEXT;
               end
            end
            default: begin
               phase_in = PH_TEXT;
            end
         endcase

         if (handle) begin
            priority if (in_byte == CHAR_NUL) begin
               ended_in = 1'b1;
            end else if (in_byte == CHAR_COLOR) begin
               phase_in = PH_COLOR;
            end else if (in_byte == CHAR_BOLD || in_byte == CHAR_UNDERLINE ||
                         in_byte == CHAR_REVERSE || in_byte == CHAR_RESET) begin
               emit = 1'b0;
            end else if (in_byte[BYTE_W-1]) begin
               emit  = 1'b1;
               clean = CHAR_QUESTION;
            end else begin
               emit = 1'b1;
            end
         end
      end

      // window of folded bytes, newest low
      recent_shift = RECENT_W'({recent_ff, fold_case(clean)});
      recent_in    = emit ? recent_shift : recent_ff;

      // keyword compare against the shifted window
      match = 1'b0;
      for (int k = 0; k < KEY_COUNT; k++) begin
         len_eff = (key_len_ff[k] > KEY_CHARS_LEN) ? KEY_CHARS_LEN : key_len_ff[k];
         hit     = (key_len_ff[k] != '0);
         for (int i = 0; i < KEY_CHARS; i++) begin
            key_byte = key_ff[k][BYTE_W*i +: BYTE_W];
            if (KEY_LEN_W'(i) < len_eff) begin
               if (key_byte == CHAR_NUL ||
                   fold_case(key_byte) != recent_shift[BYTE_W*i +: BYTE_W]) begin
                  hit = 1'b0;
               end
            end
         end
         match = match | hit;
      end
      seen_in = seen_ff | (emit & match);

      // row wrap; zero width acts as one
      width_eff = (wrap_width_ff == '0) ? BYTE_W'(1) : wrap_width_ff;
      row_inc   = row_ff + BYTE_W'(1);
      wrap      = emit && (row_inc >= width_eff);
      row_in    = emit ? (wrap ? '0 : row_inc) : row_ff;

      pend_new.text = emit;
      pend_new.cr   = wrap || (req_tlast && row_in != '0);
      pend_new.lf   = pend_new.cr;
      pend_new.beep = req_tlast && seen_in;

      // line end clears everything
      if (req_tlast) begin
         phase_in  = PH_TEXT;
         row_in    = '0;
         recent_in = '0;
         seen_in   = 1'b0;
         ended_in  = 1'b0;
      end
   end

   // output sequencing: lowest pending result goes out first
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      pend_drop    = pend_ff;

      if (out_free) begin
         rsp_valid_in = pend_busy;
      end
      if (out_load) begin
         rsp_user_in = 1'b0;
         rsp_last_in = eol_ff && $onehot(pend_ff);
         priority if (pend_ff.text) begin
            rsp_data_in    = text_ff;
            pend_drop.text = 1'b0;
         end else if (pend_ff.cr) begin
            rsp_data_in  = CHAR_CR;
            pend_drop.cr = 1'b0;
         end else if (pend_ff.lf) begin
            rsp_data_in  = CHAR_LF;
            pend_drop.lf = 1'b0;
         end else begin
            rsp_data_in    = CHAR_NUL;
            rsp_user_in    = 1'b1;
            pend_drop.beep = 1'b0;
         end
      end

      pend_in = req_accept ? pend_new : pend_drop;
      text_in = req_accept ? clean : text_ff;
      eol_in  = req_accept ? req_tlast : eol_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_width_ff <= WRAP_WIDTH_RESET;
         for (int k = 0; k < KEY_COUNT; k++) begin
            key_ff[k]     <= '0;
            key_len_ff[k] <= '0;
         end
         phase_ff     <= PH_TEXT;
         row_ff       <= '0;
         recent_ff    <= '0;
         seen_ff      <= 1'b0;
         ended_ff     <= 1'b0;
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_WRAP_WIDTH:   wrap_width_ff <= csr_data[BYTE_W-1:0];
               CSR_KEY_A:        key_ff[0]     <= csr_data;
               CSR_KEY_A_LENGTH: key_len_ff[0] <= csr_data[KEY_LEN_W-1:0];
               CSR_KEY_B:        key_ff[1]     <= csr_data;
               CSR_KEY_B_LENGTH: key_len_ff[1] <= csr_data[KEY_LEN_W-1:0];
               CSR_KEY_C:        key_ff[2]     <= csr_data;
               CSR_KEY_C_LENGTH: key_len_ff[2] <= csr_data[KEY_LEN_W-1:0];
               default: begin
               end
            endcase
         end
         if (req_accept) begin
            phase_ff  <= phase_in;
            row_ff    <= row_in;
            recent_ff <= recent_in;
            seen_ff   <= seen_in;
            ended_ff  <= ended_in;
         end
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      text_ff     <= text_in;
      eol_ff      <= eol_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   // new beats only come in when at most one result is still owed
   a_ready_backlog: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> ($countones(pend_ff) <= 1))
      else $error("req_tready with more than one result pending");

   // a beep carries a zero byte and always closes its line
   a_beep_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_user_ff) |-> (rsp_data_ff == CHAR_NUL && rsp_last_ff))
      else $error("beep beat malformed");

   // line end leaves the line state cleared
   a_line_clear: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_tlast) |=> (row_ff == '0 && !seen_ff && !ended_ff))
      else $error("line state not cleared at line end");

   // a CR is always followed by its LF in the pending set
   a_crlf_pair: assert property (@(posedge clock) disable iff (reset)
      pend_ff.cr |-> pend_ff.lf)
      else $error("CR pending without LF");

endmodule

[sim/chat_line_clean_checker.sv]
// Scoreboard for the chat line cleaner: mirrors registers, predicts result beats, compares.
module chat_line_clean_checker #(
   parameter int KEY_CHARS = clswh_pkg::KEY_CHARS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] in_byte
   input  logic        req_tlast,    // end_of_line
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,    // [7:0] out_byte
   input  logic        rsp_tuser,    // [0] is_beep
   input  logic        rsp_tlast,    // line_done
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data,
   output int          mismatches,
   output int          outstanding
);
   import clswh_pkg::*;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              beep;
      logic              done;
   } out_beat_type;

   localparam logic [KEY_W-1:0] WINDOW_MASK =
      (KEY_CHARS >= 8) ? {KEY_W{1'b1}} : ((64'd1 << (8 * KEY_CHARS)) - 64'd1);

   // register mirror
   logic [BYTE_W-1:0]    row_limit;
   logic [KEY_W-1:0]     key_word [KEY_COUNT];
   logic [KEY_LEN_W-1:0] key_len  [KEY_COUNT];

   // per-line state
   strip_phase_type      color_state;
   logic [BYTE_W-1:0]    col_count;
   logic [KEY_W-1:0]     tail_window;
   logic                 hit_flag;
   logic                 nul_seen;

   out_beat_type         step_beats [4];
   int                   step_count;
   out_beat_type         owed_q [$];
   out_beat_type         want;

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return (c >= "A" && c <= "Z") ? (c | 8'h20) : c;
   endfunction

   // zero length disables; a zero char in the used part never matches
   function automatic logic key_hits(input logic [KEY_W-1:0] word,
                                     input logic [KEY_LEN_W-1:0] len);
      int         n;
      logic [7:0] k;
      n = (int'(len) > KEY_CHARS) ? KEY_CHARS : int'(len);
      if (n == 0) return 1'b0;
      for (int i = 0; i < n; i++) begin
         k = word[8*i +: 8];
         if (k == CHAR_NUL || to_lower(k) != tail_window[8*i +: 8]) return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic add_beat(input logic [7:0] data, input logic beep);
      step_beats[step_count] = {data, beep, 1'b0};
      step_count++;
   endtask

   task automatic clear_line();
      color_state = PH_TEXT;
      col_count   = '0;
      tail_window = '0;
      hit_flag    = 1'b0;
      nul_seen    = 1'b0;
   endtask

   task automatic emit_text(input logic [7:0] c);
      logic [7:0] width;
      width = (row_limit == 8'd0) ? 8'd1 : row_limit;
      tail_window = ((tail_window << 8) | {56'd0, to_lower(c)}) & WINDOW_MASK;
      if (key_hits(key_word[0], key_len[0]) || key_hits(key_word[1], key_len[1]) ||
          key_hits(key_word[2], key_len[2]))
         hit_flag = 1'b1;
      add_beat(c, 1'b0);
      col_count = col_count + 8'd1;
      if (col_count >= width) begin
         add_beat(CHAR_CR, 1'b0);
         add_beat(CHAR_LF, 1'b0);
         col_count = '0;
      end
   endtask

   task automatic predict_line_byte(input logic [7:0] raw, input logic eol);
      logic pass_on;
      logic digit;
      step_count = 0;
      digit      = (raw >= CHAR_ZERO && raw <= CHAR_NINE);
      if (!nul_seen) begin
         pass_on = 1'b1;
         case (color_state)
            PH_COLOR: begin
               if (digit) begin
                  pass_on = 1'b0;
               end else if (raw == CHAR_COMMA) begin
                  color_state = PH_COMMA;
                  pass_on     = 1'b0;
               end else begin
                  color_state = PH_TEXT;
               end
            end
            PH_COMMA: begin
               if (digit) pass_on = 1'b0;
               else color_state = PH_TEXT;
            end
            default: color_state = PH_TEXT;
         endcase
         if (pass_on) begin
            if (raw == CHAR_NUL) begin
               nul_seen = 1'b1;
            end else if (raw == CHAR_COLOR) begin
               color_state = PH_COLOR;
            end else if (!(raw == CHAR_BOLD || raw == CHAR_UNDERLINE ||
                           raw == CHAR_REVERSE || raw == CHAR_RESET)) begin
               emit_text((raw >= 8'h80) ? CHAR_QUESTION : raw);
            end
         end
      end
      if (eol) begin
         if (col_count != 8'd0) begin
            add_beat(CHAR_CR, 1'b0);
            add_beat(CHAR_LF, 1'b0);
         end
         if (hit_flag) add_beat(CHAR_NUL, 1'b1);
         if (step_count > 0) step_beats[step_count-1].done = 1'b1;
         clear_line();
      end
      for (int i = 0; i < step_count; i++) owed_q.push_back(step_beats[i]);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         row_limit  = WRAP_WIDTH_RESET;
         for (int i = 0; i < KEY_COUNT; i++) begin
            key_word[i] = '0;
            key_len[i]  = '0;
         end
         clear_line();
         owed_q.delete();
         mismatches = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_WRAP_WIDTH:   row_limit   = csr_data[7:0];
               CSR_KEY_A:        key_word[0] = csr_data;
               CSR_KEY_A_LENGTH: key_len[0]  = csr_data[3:0];
               CSR_KEY_B:        key_word[1] = csr_data;
               CSR_KEY_B_LENGTH: key_len[1]  = csr_data[3:0];
               CSR_KEY_C:        key_word[2] = csr_data;
               CSR_KEY_C_LENGTH: key_len[2]  = csr_data[3:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) predict_line_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (owed_q.size() == 0) begin
               $error("unexpected result beat: out_byte=%h is_beep=%b line_done=%b",
                      rsp_tdata, rsp_tuser, rsp_tlast);
               mismatches++;
            end else begin
               want = owed_q.pop_front();
               if (rsp_tdata !== want.data) begin
                  $error("out_byte: expected %h, actual %h", want.data, rsp_tdata);
                  mismatches++;
               end
               if (rsp_tuser !== want.beep) begin
                  $error("is_beep: expected %b, actual %b", want.beep, rsp_tuser);
                  mismatches++;
               end
               if (rsp_tlast !== want.done) begin
                  $error("line_done: expected %b, actual %b", want.done, rsp_tlast);
                  mismatches++;
               end
            end
         end
      end
      outstanding = owed_q.size();
   end

endmodule

[sim/chat_line_code_strip_wrap_highlight_unit_tb.sv]
// Testbench top for the chat line cleaner: drives lines and register writes, gives the verdict.
module chat_line_code_strip_wrap_highlight_unit_tb;
   import clswh_pkg::*;

   localparam int RESET_CYCLES = 12;
   localparam int IDLE_PCT     = 25;     // percent of cycles a side holds off
   localparam int DRAIN_CYCLES = 8;      // settle time after the last owed beat
   localparam int STALL_LIMIT  = 2000;   // cycles with no beat on any channel
   localparam int PHASE_BEATS  = 14;     // random input beats per register setting

   logic          clock      = 1'b0;
   logic          reset      = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [7:0]    req_tdata  = '0;
   logic          req_tlast  = 1'b0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [7:0]    rsp_tdata;
   logic          rsp_tuser;
   logic          rsp_tlast;
   logic          csr_valid  = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index  = CSR_WRAP_WIDTH;
   logic [63:0]   csr_data   = '0;

   logic          calm       = 1'b0;     // high: neither side idles
   int            quiet_cycles = 0;
   int            mismatches;
   int            outstanding;

   always #4 clock = ~clock;

   chat_line_code_strip_wrap_highlight_unit dut (.*);

   chat_line_clean_checker line_watch (.*);

   // Receiver backpressure: random stalls except during the calm stretch.
   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
   end

   // Watchdog: any beat on any channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // One input beat. Random idle cycles before it; tvalid stays high between
   // back-to-back beats so it is never dropped and raised in the same step.
   task automatic send_beat(input logic [7:0] b, input logic eol);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eol;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_text(input string s, input logic eol);
      for (int i = 0; i < s.len(); i++) send_beat(s[i], eol && (i == s.len() - 1));
   endtask

   // Hold the sender until every owed result beat is out, then let the block settle.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // Writes all seven registers; junk in the unused upper bits of the narrow ones.
   task automatic configure(input logic [7:0] wrap,
                            input logic [63:0] ka, input logic [3:0] la,
                            input logic [63:0] kb, input logic [3:0] lb,
                            input logic [63:0] kc, input logic [3:0] lc);
      logic [63:0] junk;
      junk = {$urandom, $urandom};
      write_reg(CSR_WRAP_WIDTH,   {junk[63:8], wrap});
      write_reg(CSR_KEY_A,        ka);
      write_reg(CSR_KEY_A_LENGTH, {junk[63:4], la});
      write_reg(CSR_KEY_B,        kb);
      write_reg(CSR_KEY_B_LENGTH, {junk[59:0], lb});
      write_reg(CSR_KEY_C,        kc);
      write_reg(CSR_KEY_C_LENGTH, {junk[61:2], lc});
      csr_valid <= 1'b0;
   endtask

   // Small alphabet, mixed case, so keyword hits are common.
   function automatic logic [7:0] key_letter();
      case ($urandom_range(4))
         0:       return "a";
         1:       return "b";
         2:       return "c";
         3:       return "A";
         default: return "B";
      endcase
   endfunction

   // Used chars from the alphabet, garbage above them.
   function automatic logic [63:0] random_key(input int n);
      logic [63:0] k;
      k = {$urandom, $urandom};
      for (int i = 0; i < n && i < 8; i++) k[8*i +: 8] = key_letter();
      return k;
   endfunction

   // Mostly text, plus color runs, digits, commas, format codes, NUL and high bytes.
   function automatic logic [7:0] pick_byte();
      int roll;
      roll = $urandom_range(99);
      if (roll < 45) return key_letter();
      if (roll < 54) return CHAR_COLOR;
      if (roll < 64) return 8'(CHAR_ZERO + 8'($urandom_range(9)));
      if (roll < 68) return CHAR_COMMA;
      if (roll < 74) begin
         case ($urandom_range(3))
            0:       return CHAR_BOLD;
            1:       return CHAR_UNDERLINE;
            2:       return CHAR_REVERSE;
            default: return CHAR_RESET;
         endcase
      end
      if (roll < 77) return CHAR_NUL;
      if (roll < 83) return 8'(8'h80 + 8'($urandom_range(127)));
      return 8'($urandom_range(255));
   endfunction

   initial begin
      int          sent;
      int          n;
      logic [7:0]  wrap;
      logic [63:0] ka, kb, kc;
      logic [3:0]  la, lb, lc;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: 4-wide rows, "ab" key, "overflow" with an oversized length,
      // and a key with a zero char in its used part that must never hit.
      configure(8'd4, 64'h6162, 4'd2, 64'h6f76_6572_666c_6f77, 4'd15,
                64'h0000_0000_0078_0079, 4'd3);

      // Case-blind hit on the last byte: text, CR LF, beep all from one beat.
      send_text("aB", 1'b1);
      // Format codes dropped; color with digits, comma and digits dropped.
      send_beat(CHAR_BOLD, 1'b0);
      send_beat("x", 1'b0);
      send_beat(CHAR_UNDERLINE, 1'b0);
      send_beat(CHAR_REVERSE, 1'b0);
      send_beat(CHAR_RESET, 1'b0);
      send_beat(CHAR_COLOR, 1'b0);
      send_beat("1", 1'b0);
      send_beat(CHAR_COMMA, 1'b0);
      send_beat("3", 1'b0);
      send_beat("k", 1'b1);
      // Color eats only one comma; high bytes turn into '?'.
      send_beat(CHAR_COLOR, 1'b0);
      send_beat(CHAR_COMMA, 1'b0);
      send_beat(CHAR_COMMA, 1'b0);
      send_beat(8'h80, 1'b0);
      send_beat(8'hFF, 1'b1);
      // Bytes after NUL ignored through the line end.
      send_beat("q", 1'b0);
      send_beat(CHAR_NUL, 1'b0);
      send_beat("r", 1'b1);
      // Empty lines: nothing comes back, not even line_done.
      send_beat(CHAR_NUL, 1'b1);
      send_beat(CHAR_BOLD, 1'b1);
      // Exactly one full row: wrap CR LF, no second CR LF at line end.
      send_text("wxyz", 1'b1);

      // Random phases: wrap width 0, 1, 255, reset value, then random widths.
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0:       wrap = 8'd0;
            1:       wrap = 8'd1;
            2:       wrap = 8'd255;
            3:       wrap = WRAP_WIDTH_RESET;
            4:       wrap = 8'($urandom_range(2, 12));
            default: wrap = 8'($urandom_range(1, 255));
         endcase
         ka = random_key(8);
         kb = random_key(8);
         kc = random_key(8);
         la = 4'($urandom_range(1, 3));
         lb = (ph == 2) ? 4'd8 : 4'($urandom_range(0, 8));
         lc = (ph == 1) ? 4'd15 : ((ph == 0) ? 4'd0 : 4'($urandom_range(0, 4)));
         if (ph == 4) begin
            // high byte in the used part of the first key: that key cannot hit
            la        = 4'd2;
            ka[15:8]  = 8'(8'h80 + 8'($urandom_range(127)));
         end

         wait_drained();
         calm <= (ph == 3);
         configure(wrap, ka, la, kb, lb, kc, lc);

         sent = 0;
         while (sent < PHASE_BEATS) begin
            n = $urandom_range(1, 10);
            for (int i = 0; i < n; i++) send_beat(pick_byte(), i == n - 1);
            sent += n;
            // mid-phase hold-off until the block has nothing owed
            if (ph == 2 && sent == n) wait_drained();
         end
      end

      wait_drained();
      if (mismatches == 0 && outstanding == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
